/* design/shabsh_pkg.sv */
// Shared types, constants and SHA-256 helper functions for the byte-stream hasher.
// Used by shabsh_ctrl, shabsh_dp and the top level; depends on nothing else.
`default_nettype none

package shabsh_pkg;

  localparam int WordW   = 32;
  localparam int NumWork = 8;
  localparam int NumSch  = 16;

  // Byte source select for the block buffer
  localparam logic [1:0] BSEL_DATA = 2'd0;
  localparam logic [1:0] BSEL_PAD  = 2'd1;
  localparam logic [1:0] BSEL_ZERO = 2'd2;
  localparam logic [1:0] BSEL_LEN  = 2'd3;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic       put_byte;
    logic [1:0] byte_sel;
    logic       count_bits;
    logic [2:0] len_idx;
    logic       load_work;
    logic       round;
    logic [5:0] rnd_idx;
    logic       add_hash;
    logic       init_msg;
    logic [2:0] word_idx;
  } shabsh_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } shabsh_sts_t;

  function automatic word_t rotr(input word_t v, input int s);
    return (v >> s) | (v << (WordW - s));
  endfunction

  function automatic word_t big_sigma0(input word_t v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t v;
    case (idx)
      6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7; 6'd63: v = 32'hc67178f2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/shabsh_dp.sv */
// Datapath: byte packer, 16-word schedule window, round unit, chaining words and bit count.
// Driven by shabsh_ctrl through shabsh_cmd_t; depends on shabsh_pkg.
`default_nettype none

module shabsh_dp (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire [7:0]                 in_byte,
  input  shabsh_pkg::shabsh_cmd_t   cmd,
  output shabsh_pkg::shabsh_sts_t   sts,
  output logic [31:0]               digest_word
);
  import shabsh_pkg::*;

  word_t       chain_r [NumWork];
  word_t       chain_nxt [NumWork];
  word_t       work_r [NumWork];
  word_t       work_nxt [NumWork];
  word_t       win_r [NumSch];
  word_t       win_nxt [NumSch];
  logic [23:0] acc_r, acc_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;

  logic [7:0]  len_byte;
  logic [7:0]  put_val;
  word_t       sched_new;
  word_t       tmp1, tmp2, choose, major;

  // Length bytes go out most significant first
  assign len_byte = 8'(bits_r >> {~cmd.len_idx, 3'b000});

  assign sched_new = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];

  assign choose = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign major  = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign tmp1   = work_r[7] + big_sigma1(work_r[4]) + choose + round_k(cmd.rnd_idx) + win_r[0];
  assign tmp2   = big_sigma0(work_r[0]) + major;

  always_comb begin
    case (cmd.byte_sel)
      BSEL_DATA: put_val = in_byte;
      BSEL_PAD:  put_val = PAD_BYTE;
      BSEL_ZERO: put_val = 8'h00;
      BSEL_LEN:  put_val = len_byte;
      default:   put_val = 8'h00;
    endcase
  end

  always_comb begin
    chain_nxt = chain_r;
    work_nxt  = work_r;
    win_nxt   = win_r;
    acc_nxt   = acc_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;

    if (cmd.put_byte) begin
      acc_nxt  = {acc_r[15:0], put_val};
      fill_nxt = fill_r + 6'd1;
      // a fourth byte completes a word: push it into the window
      if (fill_r[1:0] == 2'b11) begin
        for (int i = 0; i < NumSch - 1; i++) win_nxt[i] = win_r[i + 1];
        win_nxt[NumSch - 1] = {acc_r, put_val};
      end
    end
    if (cmd.count_bits) bits_nxt = bits_r + 64'd8;

    if (cmd.load_work) work_nxt = chain_r;

    if (cmd.round) begin
      for (int i = 0; i < NumSch - 1; i++) win_nxt[i] = win_r[i + 1];
      win_nxt[NumSch - 1] = sched_new;
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + tmp1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = tmp1 + tmp2;
    end

    if (cmd.add_hash) begin
      for (int i = 0; i < NumWork; i++) chain_nxt[i] = chain_r[i] + work_r[i];
    end

    if (cmd.init_msg) begin
      for (int i = 0; i < NumWork; i++) chain_nxt[i] = init_hash(3'(i));
      fill_nxt = '0;
      bits_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumWork; i++) chain_r[i] <= init_hash(3'(i));
      fill_r <= '0;
      bits_r <= '0;
    end else begin
      chain_r <= chain_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    win_r  <= win_nxt;
    acc_r  <= acc_nxt;
  end

  assign sts.fill    = fill_r;
  assign digest_word = chain_r[cmd.word_idx];

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_byte && (fill_r == FILL_LAST) |=> fill_r == 6'd0)
    else $error("block fill did not wrap after the last byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.round && cmd.put_byte))
    else $error("round and byte load collide on the schedule window");

endmodule

`default_nettype wire

/* design/shabsh_ctrl.sv */
// Controller: request handshakes, padding and length sequencing, round count, digest readout.
// Drives shabsh_dp through shabsh_cmd_t; depends on shabsh_pkg.
`default_nettype none

module shabsh_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire                       byte_present,
  input  wire                       end_of_message,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [2:0]                word_number,
  output logic                      last_word,
  input  shabsh_pkg::shabsh_sts_t   sts,
  output shabsh_pkg::shabsh_cmd_t   cmd
);
  import shabsh_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] RES_IDLE = 2'd0;
  localparam logic [1:0] RES_PAD  = 2'd1;
  localparam logic [1:0] RES_OUT  = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] resume_r, resume_nxt;
  logic       pad_first_r, pad_first_nxt;
  logic [2:0] len_cnt_r, len_cnt_nxt;
  logic [5:0] rnd_cnt_r, rnd_cnt_nxt;
  logic [2:0] word_cnt_r, word_cnt_nxt;
  logic       block_full;

  assign block_full = (sts.fill == FILL_LAST);

  always_comb begin
    state_nxt     = state_r;
    resume_nxt    = resume_r;
    pad_first_nxt = pad_first_r;
    len_cnt_nxt   = len_cnt_r;
    rnd_cnt_nxt   = rnd_cnt_r;
    word_cnt_nxt  = word_cnt_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;

    cmd            = '0;
    cmd.len_idx    = len_cnt_r;
    cmd.rnd_idx    = rnd_cnt_r;
    cmd.word_idx   = word_cnt_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.put_byte   = byte_present;
          cmd.byte_sel   = BSEL_DATA;
          cmd.count_bits = byte_present;
          pad_first_nxt  = end_of_message;
          if (byte_present && block_full) begin
            cmd.load_work = 1'b1;
            rnd_cnt_nxt   = '0;
            resume_nxt    = end_of_message ? RES_PAD : RES_IDLE;
            state_nxt     = S_RND;
          end else if (end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (!pad_first_r && (sts.fill == LEN_START)) begin
          len_cnt_nxt = '0;
          state_nxt   = S_LEN;
        end else begin
          cmd.put_byte  = 1'b1;
          cmd.byte_sel  = pad_first_r ? BSEL_PAD : BSEL_ZERO;
          pad_first_nxt = 1'b0;
          if (block_full) begin
            cmd.load_work = 1'b1;
            rnd_cnt_nxt   = '0;
            resume_nxt    = RES_PAD;
            state_nxt     = S_RND;
          end
        end
      end
      S_LEN: begin
        cmd.put_byte = 1'b1;
        cmd.byte_sel = BSEL_LEN;
        len_cnt_nxt  = len_cnt_r + 3'd1;
        if (len_cnt_r == 3'd7) begin
          cmd.load_work = 1'b1;
          rnd_cnt_nxt   = '0;
          resume_nxt    = RES_OUT;
          state_nxt     = S_RND;
        end
      end
      S_RND: begin
        cmd.round   = 1'b1;
        rnd_cnt_nxt = rnd_cnt_r + 6'd1;
        if (rnd_cnt_r == 6'd63) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add_hash = 1'b1;
        word_cnt_nxt = '0;
        case (resume_r)
          RES_PAD: state_nxt = S_PAD;
          RES_OUT: state_nxt = S_OUT;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          word_cnt_nxt = word_cnt_r + 3'd1;
          if (word_cnt_r == 3'd7) begin
            // restart from the initial hash for the next message
            cmd.init_msg = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign word_number = word_cnt_r;
  assign last_word   = (word_cnt_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      resume_r    <= RES_IDLE;
      pad_first_r <= 1'b0;
      len_cnt_r   <= '0;
      rnd_cnt_r   <= '0;
      word_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      resume_r    <= resume_nxt;
      pad_first_r <= pad_first_nxt;
      len_cnt_r   <= len_cnt_nxt;
      rnd_cnt_r   <= rnd_cnt_nxt;
      word_cnt_r  <= word_cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output requests open at once");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND) && (rnd_cnt_r == 6'd63) |=> state_r == S_ADD)
    else $error("round 63 not followed by hash update");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEN) && (len_cnt_r == 3'd7) |-> block_full)
    else $error("length field does not end the block");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_work |-> cmd.put_byte && block_full)
    else $error("compression started on a partial block");

endmodule

`default_nettype wire

/* design/sha256_byte_stream_hasher_unit.sv */
// SHA-256 byte-stream hasher: up to one message byte per request, eight digest words per message.
// A byte that fills a block starts a compression (64 rounds, then the hash add); in_ready is low until it ends.
// End of message: pad bytes, the eight length bytes, one or two compressions, then the 8 digest words.
// Throughput: one byte per cycle while in_ready is high; with one round unit, each 64-byte block holds input off.
// Reset (synchronous, rst_n low): idle, chaining words at the initial hash, count and fill clear.
// Built from shabsh_ctrl and shabsh_dp; depends on shabsh_pkg.
`default_nettype none

module sha256_byte_stream_hasher_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_byte_present,
  input  wire         in_end_of_message,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);
  import shabsh_pkg::*;

  shabsh_cmd_t cmd;
  shabsh_sts_t sts;

  shabsh_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .byte_present   (in_byte_present),
    .end_of_message (in_end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .word_number    (out_word_number),
    .last_word      (out_last_word),
    .sts            (sts),
    .cmd            (cmd)
  );

  shabsh_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_data_byte),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (out_digest_word)
  );

endmodule

`default_nettype wire
